/* hdl/wpra_pkg.sv */
// ----------------------------------------------------------------------------
// wpra_pkg
// shared constants for the sliding-window peak counter and its checker
// ----------------------------------------------------------------------------
package wpra_pkg;

  localparam int unsigned WINDOW  = 100;
  localparam int unsigned CENTRES = WINDOW - 2;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned THR_W    = 7;
  localparam int unsigned SHOWN_W  = 6;

  // running count holds 0..CENTRES, seen counter holds 0..WINDOW
  localparam int unsigned CNT_W  = $clog2(CENTRES + 1);
  localparam int unsigned SEEN_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(25);
  localparam logic [SHOWN_W-1:0] SHOWN_MAX = '1;

endpackage

/* hdl/window_peak_rate_alarm.sv */
// ----------------------------------------------------------------------------
// window_peak_rate_alarm
// counts strict local peaks over a sliding window and flags a low peak rate
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+------------
//  in      | sink      | in_sample                               | valid/stall
//  out     | source    | out_peak_count, out_window_full, out_alarm | valid/stall
//  cfg     | sink      | cfg_wr_data (peak threshold)            | cfg_wr_en
//
//  one transaction per cycle sustained while out_stall is low; a result
//  passes through the input register and the result register before it
//  shows on out_*
//  the rate is set by the update of the peak history shift line and
//  running count in the compute stage for each transaction it passes on
//  rst_n is synchronous, active low; it clears the sample history, the
//  peak flags, the counters and loads the threshold with 25
//  a stalled result holds its payload; the input register keeps accepting
//  while it is empty or the compute stage can drain into the result register
// ----------------------------------------------------------------------------
module window_peak_rate_alarm (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [wpra_pkg::SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wpra_pkg::SHOWN_W-1:0]      out_peak_count,
  output logic                              out_window_full,
  output logic                              out_alarm,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [wpra_pkg::THR_W-1:0]        cfg_wr_data
);

  // input register
  logic                                 s1_vld_r;
  logic signed [wpra_pkg::SAMPLE_W-1:0] s1_sample_r;

  // running state
  logic signed [wpra_pkg::SAMPLE_W-1:0] last_r;
  logic signed [wpra_pkg::SAMPLE_W-1:0] last2_r;
  logic [wpra_pkg::CENTRES-1:0]         hist_r;
  logic [wpra_pkg::CNT_W-1:0]           cnt_r;
  logic [wpra_pkg::SEEN_W-1:0]          seen_r;
  logic [wpra_pkg::THR_W-1:0]           thr_r;

  // result register
  logic                                 out_vld_r;
  logic [wpra_pkg::SHOWN_W-1:0]         out_cnt_r;
  logic                                 out_full_r;
  logic                                 out_alarm_r;

  // compute stage
  logic                                 out_adv;
  logic                                 s1_fire;
  logic                                 in_fire;
  logic                                 flag;
  logic                                 leaving;
  logic [wpra_pkg::CNT_W-1:0]           cnt_nxt;
  logic [wpra_pkg::SEEN_W-1:0]          seen_nxt;
  logic                                 full_nxt;
  logic [wpra_pkg::SHOWN_W-1:0]         shown_nxt;
  logic                                 alarm_nxt;

  // result register can take a new value when empty or being drained
  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_fire  = s1_vld_r && out_adv;
  // input register frees up whenever its content moves on
  assign in_stall = s1_vld_r && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    // the previous sample becomes a peak once its right neighbour arrives
    flag = (seen_r >= wpra_pkg::SEEN_W'(2)) && (last_r > last2_r)
           && (last_r > s1_sample_r);
    // the flag that falls out of the window of centres
    leaving = hist_r[wpra_pkg::CENTRES-1];
    cnt_nxt = cnt_r + wpra_pkg::CNT_W'(flag) - wpra_pkg::CNT_W'(leaving);

    if (seen_r < wpra_pkg::SEEN_W'(wpra_pkg::WINDOW)) begin
      seen_nxt = seen_r + wpra_pkg::SEEN_W'(1);
    end else begin
      seen_nxt = seen_r;
    end
    full_nxt = (seen_nxt >= wpra_pkg::SEEN_W'(wpra_pkg::WINDOW));

    // shown count saturates, the alarm compares the full count
    if (wpra_pkg::CMP_W'(cnt_nxt) > wpra_pkg::CMP_W'(wpra_pkg::SHOWN_MAX)) begin
      shown_nxt = wpra_pkg::SHOWN_MAX;
    end else begin
      shown_nxt = wpra_pkg::SHOWN_W'(cnt_nxt);
    end
    alarm_nxt = full_nxt && (wpra_pkg::CMP_W'(cnt_nxt) < wpra_pkg::CMP_W'(thr_r));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      last_r    <= '0;
      last2_r   <= '0;
      hist_r    <= '0;
      cnt_r     <= '0;
      seen_r    <= '0;
      thr_r     <= wpra_pkg::THR_RESET;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (out_adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_fire) begin
        // shift the sample pair and the peak flag line by one centre
        last2_r <= last_r;
        last_r  <= s1_sample_r;
        hist_r  <= {hist_r[wpra_pkg::CENTRES-2:0], flag};
        cnt_r   <= cnt_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
    end
    if (s1_fire) begin
      out_cnt_r   <= shown_nxt;
      out_full_r  <= full_nxt;
      out_alarm_r <= alarm_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_peak_count  = out_cnt_r;
  assign out_window_full = out_full_r;
  assign out_alarm       = out_alarm_r;

endmodule

/* hdl/wpra_checker.sv */
// ----------------------------------------------------------------------------
// wpra_checker
// port-level checks for the sliding-window peak counter
// ----------------------------------------------------------------------------
module wpra_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [wpra_pkg::SHOWN_W-1:0] out_peak_count,
  input logic                         out_window_full,
  input logic                         out_alarm
);

  // stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_peak_count) && $stable(out_window_full)
      && $stable(out_alarm))
    else $error("stalled result changed");

  // alarm only with a full window
  a_alarm_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_alarm || out_window_full)
    else $error("alarm without full window");

  // once full, every later result stays full until reset
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_full |=> !out_valid || out_window_full)
    else $error("window full flag fell");

endmodule

bind window_peak_rate_alarm wpra_checker u_wpra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_peak_count  (out_peak_count),
  .out_window_full (out_window_full),
  .out_alarm       (out_alarm)
);
